// ----- src/sqd_pkg.sv -----
package sqd_pkg;

	localparam int NUM_QUEUES = 5;
	localparam int LENGTH_MAX = 255;

	localparam int LEN_W = 8;
	localparam int QW    = $clog2(NUM_QUEUES);
	localparam int EW    = $clog2(NUM_QUEUES + 1);
	localparam int SEL_W = 3;

	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 32;

	localparam logic [2:0] ADDR_STEAL_MIN = 3'd0;

	typedef enum logic [1:0] {
		ACT_ARRIVE = 2'd0,
		ACT_SERVE  = 2'd1,
		ACT_STEAL  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef logic [LEN_W-1:0] len_t;
	typedef len_t len_arr_t [NUM_QUEUES];

	typedef struct packed {
		logic [QW-1:0] arr_pick;
		logic          arr_full;
		logic [QW-1:0] stl_src;
		logic          stl_found;
	} pick_t;

endpackage

// ----- src/sqd_select.sv -----
module sqd_select import sqd_pkg::*; (
	input  len_t          lens [NUM_QUEUES],
	input  len_t          steal_min,
	input  logic [QW-1:0] stl_dst,
	output pick_t         pick
);

	len_t          arr_best;
	logic          arr_hit;
	logic [QW-1:0] arr_idx;
	len_t          stl_best;
	logic          stl_found;
	logic [QW-1:0] stl_idx;

	// arrival: first empty queue above index 0, else last index of minimum length
	always_comb begin
		arr_best = lens[0];
		arr_idx  = '0;
		arr_hit  = 1'b0;
		for (int j = 1; j < NUM_QUEUES; j++) begin
			if (!arr_hit) begin
				if (lens[j] == '0) begin
					arr_idx = QW'(j);
					arr_hit = 1'b1;
				end else if (lens[j] <= arr_best) begin
					arr_best = lens[j];
					arr_idx  = QW'(j);
				end
			end
		end
	end

	// steal: last index of greatest length above steal_min, excluding the thief
	always_comb begin
		stl_best  = '0;
		stl_idx   = '0;
		stl_found = 1'b0;
		for (int j = 0; j < NUM_QUEUES; j++) begin
			if (QW'(j) != stl_dst && lens[j] > steal_min && lens[j] >= stl_best) begin
				stl_best  = lens[j];
				stl_idx   = QW'(j);
				stl_found = 1'b1;
			end
		end
	end

	assign pick.arr_pick  = arr_idx;
	assign pick.arr_full  = (32'(lens[arr_idx]) >= 32'(LENGTH_MAX));
	assign pick.stl_src   = stl_idx;
	assign pick.stl_found = stl_found;

endmodule

// ----- src/shortest_queue_dispatch_with_stealing_core.sv -----
// result: registered; valid on the master side in the cycle after the accept
// throughput: one beat per cycle while m_tready is high; queue counters update at
// the accept edge, so back-to-back beats see each other's effect with no bubble
// s_tready drops only while a finished result waits for m_tready
// reset (arst_n low): all queues empty, served total zero, steal_min 1, no result pending
module shortest_queue_dispatch_with_stealing_core import sqd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [2:0] queue_sel, rest zero
	input  logic [1:0]          s_tuser,  // [1:0] action
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // [2:0] chosen_queue, [10:3] length_after,
	                                      // [13:11] empty_count, [29:14] served_total
	output logic [1:0]          m_tuser,  // [1:0] status
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	len_t          len_q [NUM_QUEUES];
	len_t          len_nxt [NUM_QUEUES];
	logic [EW-1:0] empty_q;
	logic [EW-1:0] empty_nxt;
	logic [15:0]   served_q;
	logic [15:0]   served_nxt;
	len_t          steal_min_q;
	logic          out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic [1:0]    out_user_q;

	logic [SEL_W-1:0] queue_sel;
	action_t       action;
	logic [QW-1:0] qi;
	logic          sel_oor;
	len_t          cur_len;
	pick_t         pick;
	logic          s_beat;

	logic [SEL_W-1:0] res_queue;
	len_t          res_len;
	status_t       res_status;
	logic [EW-1:0] stl_empty;

	assign queue_sel = s_tdata[SEL_W-1:0];
	assign action    = action_t'(s_tuser);
	assign qi        = queue_sel[QW-1:0];
	assign sel_oor   = (32'(queue_sel) >= 32'(NUM_QUEUES));
	assign cur_len   = sel_oor ? '0 : len_q[qi];

	assign s_tready = !out_valid_q || m_tready;
	assign s_beat   = s_tvalid && s_tready;

	sqd_select u_select (
		.lens      (len_q),
		.steal_min (steal_min_q),
		.stl_dst   (qi),
		.pick      (pick)
	);

	always_comb begin
		len_nxt    = len_q;
		empty_nxt  = empty_q;
		served_nxt = served_q;
		stl_empty  = empty_q;
		res_queue  = '0;
		res_len    = '0;
		res_status = ST_EMPTY;
		unique case (action)
			ACT_ARRIVE: begin
				res_queue = SEL_W'(pick.arr_pick);
				if (pick.arr_full) begin
					res_len    = len_q[pick.arr_pick];
					res_status = ST_FULL;
				end else begin
					if (len_q[pick.arr_pick] == '0 && empty_q != '0)
						empty_nxt = empty_q - EW'(1);
					len_nxt[pick.arr_pick] = len_q[pick.arr_pick] + LEN_W'(1);
					res_len    = len_q[pick.arr_pick] + LEN_W'(1);
					res_status = ST_DONE;
				end
			end
			ACT_SERVE: begin
				res_queue = queue_sel;
				if (!sel_oor && cur_len != '0) begin
					len_nxt[qi] = cur_len - LEN_W'(1);
					if (cur_len == LEN_W'(1))
						empty_nxt = empty_q + EW'(1);
					served_nxt = served_q + 16'd1;
					res_len    = cur_len - LEN_W'(1);
					res_status = ST_DONE;
				end
			end
			ACT_STEAL: begin
				res_queue = queue_sel;
				if (!sel_oor && cur_len != '0) begin
					res_len = cur_len;
				end else if (!sel_oor && pick.stl_found) begin
					len_nxt[pick.stl_src] = len_q[pick.stl_src] - LEN_W'(1);
					if (len_q[pick.stl_src] == LEN_W'(1))
						stl_empty = empty_q + EW'(1);
					len_nxt[qi] = LEN_W'(1);
					empty_nxt   = (stl_empty != '0) ? stl_empty - EW'(1) : stl_empty;
					res_queue   = SEL_W'(pick.stl_src);
					res_len     = LEN_W'(1);
					res_status  = ST_DONE;
				end
			end
			ACT_NONE: begin
				res_queue = '0;
			end
			default: begin
				res_queue = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_QUEUES; j++)
				len_q[j] <= '0;
			empty_q     <= EW'(NUM_QUEUES);
			served_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_beat) begin
				len_q       <= len_nxt;
				empty_q     <= empty_nxt;
				served_q    <= served_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			out_data_q <= {2'b00, served_nxt, 3'(empty_nxt), res_len, res_queue};
			out_user_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steal_min_q <= LEN_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == ADDR_STEAL_MIN) begin
			steal_min_q <= pwdata[LEN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_STEAL_MIN) ? 32'(steal_min_q) : '0;

endmodule
